FILE: design/lsw_pkg.sv
// shared types, codes and sizes for the lcd segment serial writer
// no dependencies; every other file imports this package
package lsw_pkg;

  localparam int KIND_W    = 3;
  localparam int VALUE_W   = 8;
  localparam int SHIFT_W   = 9;
  localparam int COUNT_W   = 4;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_OPEN    = 3'd0,
    KIND_COMMAND = 3'd1,
    KIND_ADDRESS = 3'd2,
    KIND_DATA    = 3'd3,
    KIND_NIBBLE  = 3'd4,
    KIND_CLOSE   = 3'd5
  } kind_t;

  // one classified item, as queued between front and back
  typedef struct packed {
    logic               pre_release;  // release rel_chip before anything else
    logic               rel_chip;
    logic               select;       // assert select of chip
    logic               close;        // release chip after the bits
    logic               chip;
    logic               level;        // select_active carried by strobed bits
    logic [SHIFT_W-1:0] bits;         // msb first, left aligned
    logic [COUNT_W-1:0] count;
  } desc_t;

endpackage

FILE: design/lsw_if.sv
// valid/ready channel interfaces for input items and result words
// depends on lsw_pkg
interface lsw_in_if;
  import lsw_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic               chip;
  logic               mode_bit;
  logic [VALUE_W-1:0] value;

  modport source (output valid, kind, chip, mode_bit, value, input ready);
  modport sink   (input valid, kind, chip, mode_bit, value, output ready);
endinterface

interface lsw_out_if;
  logic valid;
  logic ready;
  logic chip_out;
  logic select_active;
  logic strobe_res;
  logic data_bit;
  logic last;

  modport source (output valid, chip_out, select_active, strobe_res, data_bit, last,
                  input ready);
  modport sink   (input valid, chip_out, select_active, strobe_res, data_bit, last,
                  output ready);
endinterface

FILE: design/lsw_front.sv
// front end: accepts items, tracks frame state, builds descriptors
// depends on lsw_pkg and lsw_in_if
module lsw_front (
  input  logic            clk,
  input  logic            rst,
  lsw_in_if.sink          item,
  output logic            push,
  output lsw_pkg::desc_t  push_desc,
  input  logic            push_ready
);
  import lsw_pkg::*;

  logic  frame_open;
  logic  active_chip;
  logic  frame_open_next;
  logic  active_chip_next;
  logic  known;
  desc_t d;
  logic  take;

  assign item.ready = push_ready;
  assign take       = item.valid && item.ready;

  always_comb begin
    d                = '0;
    d.rel_chip       = active_chip;
    d.chip           = active_chip;
    d.level          = frame_open;
    known            = 1'b1;
    frame_open_next  = frame_open;
    active_chip_next = active_chip;
    case (kind_t'(item.kind))
      KIND_OPEN: begin
        d.pre_release    = frame_open;
        d.select         = 1'b1;
        d.chip           = item.chip;
        d.level          = 1'b1;
        d.bits           = {1'b1, 1'b0, item.mode_bit, 6'b0};
        d.count          = COUNT_W'(3);
        frame_open_next  = 1'b1;
        active_chip_next = item.chip;
      end
      KIND_COMMAND: begin
        d.bits  = {item.value, 1'b0};
        d.count = COUNT_W'(9);
      end
      KIND_ADDRESS: begin
        d.bits  = {item.value[5:0], 3'b0};
        d.count = COUNT_W'(7);
      end
      KIND_DATA: begin
        d.bits  = {item.value, 1'b0};
        d.count = COUNT_W'(8);
      end
      KIND_NIBBLE: begin
        d.bits  = {item.value[3:0], 5'b0};
        d.count = COUNT_W'(4);
      end
      KIND_CLOSE: begin
        d.close         = 1'b1;
        frame_open_next = 1'b0;
      end
      default: known = 1'b0;
    endcase
  end

  // unused kinds are taken and dropped
  assign push      = take && known;
  assign push_desc = d;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      active_chip <= 1'b0;
    end else if (take) begin
      frame_open  <= frame_open_next;
      active_chip <= active_chip_next;
    end
  end

endmodule

FILE: design/lsw_queue.sv
// short descriptor queue between front and back
// depends on lsw_pkg
module lsw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lsw_pkg::desc_t  push_desc,
  output logic            push_ready,
  input  logic            pop,
  output lsw_pkg::desc_t  pop_desc,
  output logic            pop_valid
);
  import lsw_pkg::*;

  desc_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != QCNT_W'(QDEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_desc   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QDEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: design/lsw_back.sv
// back end: steps through one descriptor, one result word per cycle while the output is not stalled
// depends on lsw_pkg and lsw_out_if
module lsw_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            desc_valid,
  input  lsw_pkg::desc_t  desc,
  output logic            desc_pop,
  lsw_out_if.source       result
);
  import lsw_pkg::*;

  logic               pend_pre;
  logic               pend_sel;
  logic               pend_close;
  logic [COUNT_W-1:0] count;
  logic [SHIFT_W-1:0] shreg;
  logic               chip;
  logic               rel_chip;
  logic               level;

  logic               pend_pre_next;
  logic               pend_sel_next;
  logic               pend_close_next;
  logic [COUNT_W-1:0] count_next;
  logic [SHIFT_W-1:0] shreg_next;
  logic               r_chip;
  logic               r_sel;
  logic               r_strobe;
  logic               r_bit;
  logic               busy;
  logic               emit;

  assign busy     = pend_pre || pend_sel || pend_close || (count != '0);
  assign emit     = busy && (!result.valid || result.ready);
  assign desc_pop = !busy && desc_valid;

  // priority: release old chip, select, data bits, close
  always_comb begin
    pend_pre_next   = pend_pre;
    pend_sel_next   = pend_sel;
    pend_close_next = pend_close;
    count_next      = count;
    shreg_next      = shreg;
    r_chip          = chip;
    r_sel           = 1'b0;
    r_strobe        = 1'b0;
    r_bit           = 1'b0;
    if (pend_pre) begin
      r_chip        = rel_chip;
      pend_pre_next = 1'b0;
    end else if (pend_sel) begin
      r_sel         = 1'b1;
      pend_sel_next = 1'b0;
    end else if (count != '0) begin
      r_sel      = level;
      r_strobe   = 1'b1;
      r_bit      = shreg[SHIFT_W-1];
      shreg_next = {shreg[SHIFT_W-2:0], 1'b0};
      count_next = count - COUNT_W'(1);
    end else begin
      pend_close_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_pre     <= 1'b0;
      pend_sel     <= 1'b0;
      pend_close   <= 1'b0;
      count        <= '0;
      result.valid <= 1'b0;
    end else begin
      if (desc_pop) begin
        pend_pre   <= desc.pre_release;
        pend_sel   <= desc.select;
        pend_close <= desc.close;
        count      <= desc.count;
        shreg      <= desc.bits;
        chip       <= desc.chip;
        rel_chip   <= desc.rel_chip;
        level      <= desc.level;
      end else if (emit) begin
        pend_pre   <= pend_pre_next;
        pend_sel   <= pend_sel_next;
        pend_close <= pend_close_next;
        count      <= count_next;
        shreg      <= shreg_next;
      end
      if (emit) begin
        result.valid         <= 1'b1;
        result.chip_out      <= r_chip;
        result.select_active <= r_sel;
        result.strobe_res    <= r_strobe;
        result.data_bit      <= r_bit;
        result.last          <= !(pend_pre_next || pend_sel_next || pend_close_next
                                  || (count_next != '0));
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/lcd_segment_serial_writer_top.sv
// top level of the lcd segment serial writer
// depends on lsw_pkg, lsw_if, lsw_front, lsw_queue, lsw_back
//
// Turns frame-level words (open, command, address, data byte, nibble, close)
// for a three-wire segment lcd controller with two chip selects into result
// words, one per select change or strobed data bit, msb first. Open gives
// 4 results (5 when a frame was already open), command 9, address 7, data
// byte 8, nibble 4, close 1; kinds 6 and 7 are taken and give nothing. The
// back end makes one result word per cycle while the output is not stalled,
// and loads the next descriptor from the two-entry queue only once it has
// finished the last one. The front end keeps the open flag and the active
// chip and keeps taking words while the back end is still shifting, until
// the queue is full. Results sit in an output register and are held while
// ready is low.
module lcd_segment_serial_writer_top (
  input  logic       clk,
  input  logic       rst,
  lsw_in_if.sink     item,
  lsw_out_if.source  result
);
  import lsw_pkg::*;

  // front to queue
  logic  push;
  logic  push_ready;
  desc_t push_desc;

  // queue to back
  logic  pop;
  logic  pop_valid;
  desc_t pop_desc;

  // classify each word and track frame state
  lsw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push       (push),
    .push_desc  (push_desc),
    .push_ready (push_ready)
  );

  // decouples the front from a stalled result side
  lsw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_desc   (pop_desc),
    .pop_valid  (pop_valid)
  );

  // serializer and output register
  lsw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (pop_valid),
    .desc       (pop_desc),
    .desc_pop   (pop),
    .result     (result)
  );

endmodule

FILE: verif/lcd_segment_serial_writer_top_tb.sv
// self-checking testbench for the lcd segment serial writer top level
// depends on lsw_pkg, lsw_if and the design files under design/
module lcd_segment_serial_writer_top_tb;
  import lsw_pkg::*;

  // the two kind codes the block takes and drops without any result
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

  // quiet wait after the last expected word, covers dropped kinds in flight
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 238;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               chip;
    logic               mode_bit;
    logic [VALUE_W-1:0] value;
  } frame_item_t;

  typedef struct packed {
    logic chip_out;
    logic select_active;
    logic strobe_res;
    logic data_bit;
    logic last;
  } result_word_t;

  logic clk;
  logic rst;

  lsw_in_if  item ();
  lsw_out_if result ();

  lcd_segment_serial_writer_top DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  // stimulus waiting to be driven, and result words still owed by the block
  frame_item_t  pending_items[$];
  result_word_t expected_words[$];

  // shadow of the framer state
  logic frame_is_open;
  logic cur_chip;

  int n_total;
  int n_sent;
  int n_mismatch;
  int send_idle_pct;
  int recv_idle_pct;
  frame_item_t next_item;

  // clock; the single reset pulse comes from the stimulus process
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle ratios by phase: sender light / receiver heavy, then swapped, then none
  always_comb begin
    if (n_sent < n_total / 3) begin
      send_idle_pct = 34;
      recv_idle_pct = 71;
    end else if (n_sent < (2 * n_total) / 3) begin
      send_idle_pct = 71;
      recv_idle_pct = 34;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  function automatic result_word_t make_word(logic c, logic sel, logic strobe, logic b);
    result_word_t w;
    w.chip_out      = c;
    w.select_active = sel;
    w.strobe_res    = strobe;
    w.data_bit      = b;
    w.last          = 1'b0;
    return w;
  endfunction

  // works out the words one accepted item causes and updates the shadow state
  function automatic void predict_frame_words(frame_item_t it);
    result_word_t       words[$];
    logic [SHIFT_W-1:0] bits;
    int                 count;
    bits  = '0;
    count = 0;
    case (it.kind)
      KIND_OPEN: begin
        // reopen while open releases the old chip first
        if (frame_is_open)
          words.push_back(make_word(cur_chip, 1'b0, 1'b0, 1'b0));
        cur_chip      = it.chip;
        frame_is_open = 1'b1;
        words.push_back(make_word(cur_chip, 1'b1, 1'b0, 1'b0));
        bits  = {6'b0, 2'b10, it.mode_bit};
        count = 3;
      end
      KIND_COMMAND: begin
        bits  = {it.value, 1'b0};
        count = 9;
      end
      KIND_ADDRESS: begin
        bits  = {2'b0, it.value[5:0], 1'b0};
        count = 7;
      end
      KIND_DATA: begin
        bits  = {1'b0, it.value};
        count = 8;
      end
      KIND_NIBBLE: begin
        bits  = {5'b0, it.value[3:0]};
        count = 4;
      end
      KIND_CLOSE: begin
        // a release is given even with no frame open
        words.push_back(make_word(cur_chip, 1'b0, 1'b0, 1'b0));
        frame_is_open = 1'b0;
      end
      default: begin
        // spare kinds: nothing out, state kept
      end
    endcase
    // strobed bits carry the open flag as select level, msb first
    for (int i = count - 1; i >= 0; i--)
      words.push_back(make_word(cur_chip, frame_is_open, 1'b1, bits[i]));
    if (words.size() > 0)
      words[words.size() - 1].last = 1'b1;
    foreach (words[j])
      expected_words.push_back(words[j]);
  endfunction

  function automatic frame_item_t make_item(logic [KIND_W-1:0] k, logic c, logic m,
                                            logic [VALUE_W-1:0] v);
    frame_item_t it;
    it.kind     = k;
    it.chip     = c;
    it.mode_bit = m;
    it.value    = v;
    return it;
  endfunction

  task automatic check_field(string name, logic exp_val, logic act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0b, got %0b", name, exp_val, act_val);
      n_mismatch++;
    end
  endtask

  // driver: a new word goes out once the previous one is taken or the line is idle
  always @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (!item.valid || item.ready) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        item.valid    <= 1'b1;
        item.kind     <= next_item.kind;
        item.chip     <= next_item.chip;
        item.mode_bit <= next_item.mode_bit;
        item.value    <= next_item.value;
        n_sent++;
      end else begin
        item.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst)
      result.ready <= 1'b0;
    else
      result.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: outputs are checked before the item taken at the same edge is
  // predicted; the output register cannot yet hold words of that item
  always @(posedge clk) begin
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: chip_out %0b select_active %0b strobe_res %0b",
                 result.chip_out, result.select_active, result.strobe_res);
          n_mismatch++;
        end else begin
          result_word_t exp_w;
          exp_w = expected_words.pop_front();
          check_field("chip_out", exp_w.chip_out, result.chip_out);
          check_field("select_active", exp_w.select_active, result.select_active);
          check_field("strobe_res", exp_w.strobe_res, result.strobe_res);
          check_field("data_bit", exp_w.data_bit, result.data_bit);
          check_field("last", exp_w.last, result.last);
        end
      end
      if (item.valid && item.ready)
        predict_frame_words(make_item(item.kind, item.chip, item.mode_bit, item.value));
    end
  end

  // watchdog
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int n_random;
    int n_body;
    frame_item_t it;

    // known levels on every block input from time zero
    rst           = 1'b1;
    item.valid    = 1'b0;
    item.kind     = KIND_OPEN;
    item.chip     = 1'b0;
    item.mode_bit = 1'b0;
    item.value    = '0;
    result.ready  = 1'b0;
    frame_is_open = 1'b0;
    cur_chip      = 1'b0;
    n_sent        = 0;
    n_mismatch    = 0;

    // directed part
    pending_items.push_back(make_item(KIND_CLOSE,   1'b0, 1'b0, 8'h00)); // close, nothing open
    pending_items.push_back(make_item(KIND_COMMAND, 1'b1, 1'b1, 8'hFF)); // bits, nothing open
    pending_items.push_back(make_item(KIND_DATA,    1'b0, 1'b0, 8'h00));
    pending_items.push_back(make_item(KIND_SPARE_A, 1'b1, 1'b1, 8'hFF)); // dropped kinds
    pending_items.push_back(make_item(KIND_SPARE_B, 1'b0, 1'b0, 8'h00));
    pending_items.push_back(make_item(KIND_OPEN,    1'b1, 1'b0, 8'hFF));
    pending_items.push_back(make_item(KIND_COMMAND, 1'b0, 1'b0, 8'h00));
    pending_items.push_back(make_item(KIND_COMMAND, 1'b0, 1'b0, 8'hFF));
    pending_items.push_back(make_item(KIND_ADDRESS, 1'b0, 1'b0, 8'hFF)); // high bits dropped
    pending_items.push_back(make_item(KIND_ADDRESS, 1'b0, 1'b0, 8'h00));
    pending_items.push_back(make_item(KIND_OPEN,    1'b0, 1'b1, 8'h00)); // reopen while open
    pending_items.push_back(make_item(KIND_DATA,    1'b0, 1'b0, 8'hFF));
    pending_items.push_back(make_item(KIND_DATA,    1'b0, 1'b0, 8'h00));
    pending_items.push_back(make_item(KIND_NIBBLE,  1'b0, 1'b0, 8'hF5)); // high nibble dropped
    pending_items.push_back(make_item(KIND_NIBBLE,  1'b0, 1'b0, 8'hA0));
    pending_items.push_back(make_item(KIND_CLOSE,   1'b1, 1'b1, 8'h00));
    pending_items.push_back(make_item(KIND_CLOSE,   1'b0, 1'b0, 8'h00)); // double close
    pending_items.push_back(make_item(KIND_OPEN,    1'b1, 1'b1, 8'h00));
    pending_items.push_back(make_item(KIND_OPEN,    1'b1, 1'b0, 8'h00)); // reopen same chip
    pending_items.push_back(make_item(KIND_DATA,    1'b0, 1'b0, 8'hA5));
    pending_items.push_back(make_item(KIND_CLOSE,   1'b0, 1'b0, 8'h00));
    pending_items.push_back(make_item(KIND_NIBBLE,  1'b0, 1'b0, 8'h0C)); // nibble, nothing open

    // random part: mostly open / body / close frames, some loose noise
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 85) begin
        pending_items.push_back(make_item(KIND_OPEN, 1'($urandom_range(1)),
                                          1'($urandom_range(1)),
                                          VALUE_W'($urandom_range(255))));
        n_random++;
        n_body = $urandom_range(1, 6);
        for (int i = 0; i < n_body; i++) begin
          it = make_item(KIND_W'($urandom_range(KIND_COMMAND, KIND_NIBBLE)),
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         VALUE_W'($urandom_range(255)));
          pending_items.push_back(it);
          n_random++;
        end
        // sometimes the frame is left open, so the next open is a reopen
        if ($urandom_range(99) < 80) begin
          pending_items.push_back(make_item(KIND_CLOSE, 1'($urandom_range(1)),
                                            1'($urandom_range(1)),
                                            VALUE_W'($urandom_range(255))));
          n_random++;
        end
      end else begin
        it = make_item(KIND_W'($urandom_range(7)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), VALUE_W'($urandom_range(255)));
        pending_items.push_back(it);
        if (it.kind <= KIND_CLOSE)
          n_random++;
      end
    end
    n_total = pending_items.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // all stimulus taken, then all results in, then a quiet tail
    while (pending_items.size() != 0 || item.valid)
      @(posedge clk);
    while (expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_mismatch == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
